// ===== src/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// bole_pkg: shared constants and types of the bounded ordered list engine
// Holds capacity, field widths, opcode and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package bole_pkg;
    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 5;
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(10);
    localparam logic [CNT_W-1:0] LIMIT_TOP   =
        CNT_W'((CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS);

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AFTER = 3'd2,
        OP_DELETE    = 3'd3,
        OP_SORT      = 3'd4,
        OP_DUMP      = 3'd5,
        OP_RSVD6     = 3'd6,
        OP_RSVD7     = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;
endpackage
`default_nettype wire

// ===== src/bole_ram.sv =====
// ----------------------------------------------------------------------------
// bole_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== src/bounded_ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: ordered list of signed words in one RAM
// Insert front/end/after, delete, bubble sort and dump over a bounded list.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_valid/o_ready carries opcode, value and anchor_value.
//   Result channel o_valid/i_ready returns status, element, entry count,
//   empty/full flags and last. A dump returns one result per entry; every
//   other command returns exactly one result.
//   Config channel i_cfg_valid/o_cfg_ready writes max_entries (always ready);
//   write it only while the engine is idle.
// Throughput: one request at a time. All list walks go through a single-port
//   RAM with registered read data: each touched entry takes a read state and
//   a check or write state (a sort step reads two entries, checks, and may
//   write back the swap). The RAM port sets the pace.
// Reset: count clears to zero, limit returns to 10, the list reads empty.
//   RAM contents are not cleared; only entries below count are used.
// Stall: a result sits in the output register until taken; the engine
//   holds until then and resumes the walk afterwards.
// ----------------------------------------------------------------------------
`default_nettype none
module bounded_ordered_list_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [2:0]                    i_opcode,
    input  wire logic signed [31:0]            i_value,
    input  wire logic signed [31:0]            i_anchor_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_status,
    output logic signed [31:0]                 o_element,
    output logic [4:0]                         o_entry_count,
    output logic                               o_is_empty,
    output logic                               o_is_full,
    output logic                               o_last,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [4:0]                    i_cfg_data
);
    import bole_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND_RD, S_FIND_CHK, S_SHIFT_RD, S_SHIFT_WR,
        S_DEL_RD, S_DEL_WR, S_SORT_RD0, S_SORT_RD1, S_SORT_CHK,
        S_SORT_WR1, S_DUMP_RD, S_DUMP_OUT, S_RESULT
    } t_state;

    t_state              r_state;
    t_opcode             r_op;
    t_status             r_status;
    logic [DATA_W-1:0]   r_val, r_anc, r_hold;
    logic [CNT_W-1:0]    r_count, r_limit, r_idx, r_pos;
    logic                r_swapped;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [DATA_W-1:0]   ram_wdata, ram_rdata;

    logic [CNT_W-1:0]    eff_limit;
    logic                full_now;

    bole_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign eff_limit   = (r_limit > LIMIT_TOP) ? LIMIT_TOP : r_limit;
    assign full_now    = r_count >= eff_limit;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // RAM port: address follows the walk index; writes in shift/delete/sort
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_idx[ADDR_W-1:0];
        ram_wdata = r_hold;
        unique case (r_state)
            S_SHIFT_RD: ram_addr = ADDR_W'(r_idx - CNT_W'(1));
            S_SHIFT_WR: begin
                ram_we = 1'b1;
                ram_wdata = (r_idx == r_pos) ? r_val : ram_rdata;
            end
            S_DEL_RD:   ram_addr = ADDR_W'(r_idx + CNT_W'(1));
            S_DEL_WR: begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_SORT_RD1: ram_addr = ADDR_W'(r_idx + CNT_W'(1));
            S_SORT_CHK: begin
                // swap: write low slot with the higher entry's value
                ram_we = $signed(r_hold) > $signed(ram_rdata);
                ram_wdata = ram_rdata;
            end
            S_SORT_WR1: begin
                ram_we = 1'b1;
                ram_addr = ADDR_W'(r_idx + CNT_W'(1));
                ram_wdata = r_hold;
            end
            default: ;
        endcase
    end

    // Result emission helper values
    logic [CNT_W-1:0] fin_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_limit <= LIMIT_RESET;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            // the result state reloads the output register itself
            if (o_valid && i_ready && r_state != S_RESULT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op  <= t_opcode'(i_opcode);
                        r_val <= i_value;
                        r_anc <= i_anchor_value;
                        r_swapped <= 1'b0;
                        unique case (t_opcode'(i_opcode))
                            OP_INS_FRONT, OP_INS_END: begin
                                if (full_now) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_RESULT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_pos <= (t_opcode'(i_opcode) == OP_INS_FRONT)
                                             ? '0 : r_count;
                                    r_idx <= r_count;
                                    r_state <= S_SHIFT_RD;
                                end
                            end
                            OP_INS_AFTER: begin
                                r_idx <= '0;
                                if (full_now) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_RESULT;
                                end else if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_RESULT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_FIND_RD;
                                end
                            end
                            OP_DELETE: begin
                                r_idx <= '0;
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_RESULT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_FIND_RD;
                                end
                            end
                            OP_SORT: begin
                                r_idx    <= '0;
                                r_status <= ST_OK;
                                if (r_count > CNT_W'(1)) r_state <= S_SORT_RD0;
                                else r_state <= S_RESULT;
                            end
                            OP_DUMP: begin
                                r_idx <= '0;
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_RESULT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_DUMP_RD;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_FIND_RD: r_state <= S_FIND_CHK;
                S_FIND_CHK: begin
                    if (ram_rdata == ((r_op == OP_DELETE) ? r_val : r_anc)) begin
                        if (r_op == OP_DELETE) begin
                            r_state <= S_DEL_RD;
                        end else begin
                            r_pos <= r_idx + CNT_W'(1);
                            r_idx <= r_count;
                            r_state <= S_SHIFT_RD;
                        end
                    end else if (r_idx + CNT_W'(1) >= r_count) begin
                        r_status <= ST_NOTFOUND;
                        r_state <= S_RESULT;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                        r_state <= S_FIND_RD;
                    end
                end
                // shift up from count down to pos, then drop value at pos
                S_SHIFT_RD: r_state <= S_SHIFT_WR;
                S_SHIFT_WR: begin
                    if (r_idx == r_pos) begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_RESULT;
                    end else begin
                        r_idx <= r_idx - CNT_W'(1);
                        r_state <= S_SHIFT_RD;
                    end
                end
                // shift down over the deleted slot
                S_DEL_RD: begin
                    if (r_idx + CNT_W'(1) >= r_count) begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    r_idx <= r_idx + CNT_W'(1);
                    r_state <= S_DEL_RD;
                end
                S_SORT_RD0: r_state <= S_SORT_RD1;
                S_SORT_RD1: begin
                    r_hold <= ram_rdata;
                    r_state <= S_SORT_CHK;
                end
                S_SORT_CHK: begin
                    if ($signed(r_hold) > $signed(ram_rdata)) begin
                        r_swapped <= 1'b1;
                        r_state <= S_SORT_WR1;
                    end else if (r_idx + CNT_W'(2) >= r_count) begin
                        if (r_swapped) begin
                            r_swapped <= 1'b0;
                            r_idx <= '0;
                            r_state <= S_SORT_RD0;
                        end else begin
                            r_state <= S_RESULT;
                        end
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                        r_state <= S_SORT_RD0;
                    end
                end
                S_SORT_WR1: begin
                    if (r_idx + CNT_W'(2) >= r_count) begin
                        r_idx <= '0;
                        r_swapped <= 1'b0;
                        r_state <= S_SORT_RD0;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                        r_state <= S_SORT_RD0;
                    end
                end
                S_DUMP_RD: begin
                    if (!o_valid || i_ready) begin
                        r_state <= S_DUMP_OUT;
                    end
                end
                S_DUMP_OUT: begin
                    o_valid       <= 1'b1;
                    o_status      <= ST_OK;
                    o_element     <= ram_rdata;
                    o_entry_count <= r_count;
                    o_is_empty    <= 1'b0;
                    o_is_full     <= full_now;
                    o_last        <= (r_idx + CNT_W'(1) == r_count);
                    if (r_idx + CNT_W'(1) == r_count) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                        r_state <= S_DUMP_RD;
                    end
                end
                S_RESULT: begin
                    if (!o_valid || i_ready) begin
                        o_valid       <= 1'b1;
                        o_status      <= r_status;
                        o_element     <= '0;
                        o_entry_count <= r_count;
                        o_is_empty    <= (r_count == '0);
                        o_is_full     <= fin_count >= eff_limit;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign fin_count = r_count;
endmodule
`default_nettype wire
